@@ design/nps_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nps_pkg
// Shared types and constants of the nearest point search block.
// ============================================================================
package nps_pkg;

    // Fixed field widths of the stream and register interface
    localparam int IDX_BITS = 10;
    localparam int USE_BITS = 11;

    // Item kinds carried in tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Sideband that travels with each point read through the distance pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } nps_tag_t;

    // Query sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } nps_state_t;

endpackage

@@ design/nearest_point_search.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nearest_point_search
// Linear nearest point search over a RAM table of 2-D fixed point coordinates.
// ============================================================================
// Write transfer: stored at the accepting edge, no result.
// Query transfer: N = min(points_in_use, MAX_POINTS) table reads, one per cycle on
//   the RAM read port, then the RAM read register and the distance pipeline; the
//   result is then loaded into the output register once it is free (no reads when N is 0).
// One query at a time; input is held off from acceptance until the result is loaded.
// Reset clears control state and points_in_use; the point table is not cleared.
// ============================================================================
module nearest_point_search #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: points_in_use
    input  logic                             cfg_wr_en,
    input  logic [nps_pkg::USE_BITS-1:0]     cfg_wr_data,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: point_index, point_x, point_y, zero pad
    input  logic [((nps_pkg::IDX_BITS + 2*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: action
    input  logic                             s_tuser,
    // Output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: nearest_index, zero pad
    output logic [15:0]                      m_tdata
);

    import nps_pkg::*;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW_MIN = $clog2(MAX_POINTS + 1);
    localparam int CNT_W  = (CW_MIN > USE_BITS) ? CW_MIN : USE_BITS;
    localparam int PT_W   = 2 * COORD_BITS;
    localparam int SUM_W  = 2 * (COORD_BITS + 1) + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    // Input field unpacking
    logic [IDX_BITS-1:0]   in_slot;
    logic [COORD_BITS-1:0] in_x, in_y;
    logic                  in_xfer;
    logic [CNT_W-1:0]      slot_ext;
    logic [CNT_W-1:0]      use_ext;
    logic [CNT_W-1:0]      count_cap;

    assign in_slot  = s_tdata[IDX_BITS-1:0];
    assign in_x     = s_tdata[IDX_BITS +: COORD_BITS];
    assign in_y     = s_tdata[IDX_BITS + COORD_BITS +: COORD_BITS];
    assign in_xfer  = s_tvalid && s_tready;
    assign slot_ext = CNT_W'(in_slot);

    // Registers
    nps_state_t            state_reg, state_next;
    logic [USE_BITS-1:0]   use_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      scan_cnt_reg;
    logic [COORD_BITS-1:0] tx_reg, ty_reg;
    nps_tag_t              rd_tag_reg;
    logic [ADDR_W-1:0]     rd_idx_reg;
    logic                  have_reg;
    logic [ADDR_W-1:0]     best_idx_reg;
    logic [SUM_W-1:0]      best_dist_reg;
    logic                  m_tvalid_reg;
    logic [IDX_BITS-1:0]   m_index_reg;

    // Control outputs of the sequencer
    logic issue;
    logic out_load;
    logic scan_last;

    // Table access
    logic              wr_en;
    logic [ADDR_W-1:0] scan_addr;
    logic [PT_W-1:0]   rd_data;

    // Distance pipeline outputs
    nps_tag_t          dist_tag;
    logic [ADDR_W-1:0] dist_idx;
    logic [SUM_W-1:0]  dist_val;
    logic              better;
    logic [CNT_W-1:0]  best_ext;

    // Scan length clamped to the table depth
    always_comb
    begin
        use_ext   = CNT_W'(use_reg);
        count_cap = (use_ext > MAX_CNT) ? MAX_CNT : use_ext;
    end

    assign scan_addr = scan_cnt_reg[ADDR_W-1:0];
    assign scan_last = (scan_cnt_reg == count_reg - 1'b1);
    assign wr_en     = in_xfer && (s_tuser == ACT_WRITE) && (slot_ext < MAX_CNT);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            use_reg <= cfg_wr_data;
        end
    end

    // Point table
    nps_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_ext[ADDR_W-1:0]),
        .wr_data ({in_y, in_x}),
        .rd_en   (issue),
        .rd_addr (scan_addr),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_tuser == ACT_QUERY))
                begin
                    state_next = (count_cap == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (dist_tag.valid && dist_tag.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        issue    = (state_reg == ST_SCAN);
        out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    end

    // Sequencer and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            rd_tag_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_tag_reg.valid <= issue;
            rd_tag_reg.last  <= issue && scan_last;
            if (in_xfer && (s_tuser == ACT_QUERY))
            begin
                count_reg    <= count_cap;
                scan_cnt_reg <= '0;
            end
            else if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    // Query point and read index
    always_ff @(posedge clk)
    begin
        if (in_xfer && (s_tuser == ACT_QUERY))
        begin
            tx_reg <= in_x;
            ty_reg <= in_y;
        end
        rd_idx_reg <= scan_addr;
    end

    // Squared distance pipeline
    nps_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (ADDR_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (rd_tag_reg),
        .in_idx   (rd_idx_reg),
        .px       (rd_data[COORD_BITS-1:0]),
        .py       (rd_data[PT_W-1:COORD_BITS]),
        .tx       (tx_reg),
        .ty       (ty_reg),
        .out_tag  (dist_tag),
        .out_idx  (dist_idx),
        .out_dist (dist_val)
    );

    // Running minimum, strict less-than keeps the lowest index on ties
    assign better = !have_reg || (dist_val < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (in_xfer && (s_tuser == ACT_QUERY))
        begin
            have_reg     <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (dist_tag.valid && better)
        begin
            have_reg     <= 1'b1;
            best_idx_reg <= dist_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_tag.valid && better)
        begin
            best_dist_reg <= dist_val;
        end
    end

    // Output register
    assign best_ext = CNT_W'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_index_reg <= best_ext[IDX_BITS-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(16 - IDX_BITS){1'b0}}, m_index_reg};

    // Assertions
    a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !rd_tag_reg.valid && !dist_tag.valid)
        else $error("input accepted while a scan is in flight");

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside of finish");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg < count_reg))
        else $error("scan address beyond points in use");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |-> (best_ext < count_reg))
        else $error("best index beyond scanned range");

endmodule

@@ design/nps_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module nps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/nps_dist.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nps_dist
// Three-stage squared distance pipeline: abs differences, squares, sum.
// ============================================================================
module nps_dist #(
    parameter int COORD_BITS = 24,
    parameter int IDX_W = 10,
    localparam int DIFF_W = COORD_BITS + 1,
    localparam int SQ_W = 2 * DIFF_W,
    localparam int SUM_W = SQ_W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  nps_pkg::nps_tag_t      in_tag,
    input  logic [IDX_W-1:0]       in_idx,
    input  logic [COORD_BITS-1:0]  px,
    input  logic [COORD_BITS-1:0]  py,
    input  logic [COORD_BITS-1:0]  tx,
    input  logic [COORD_BITS-1:0]  ty,
    output nps_pkg::nps_tag_t      out_tag,
    output logic [IDX_W-1:0]       out_idx,
    output logic [SUM_W-1:0]       out_dist
);

    import nps_pkg::*;

    nps_tag_t           tag_a_reg, tag_b_reg, tag_c_reg;
    logic [IDX_W-1:0]   idx_a_reg, idx_b_reg, idx_c_reg;
    logic [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [SQ_W-1:0]    sx_reg, sy_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic [DIFF_W-1:0]  dx_raw, dy_raw;
    logic [DIFF_W-1:0]  dx_abs, dy_abs;

    // Stage A input: sign-extended differences and their magnitudes
    always_comb
    begin
        dx_raw = {px[COORD_BITS-1], px} - {tx[COORD_BITS-1], tx};
        dy_raw = {py[COORD_BITS-1], py} - {ty[COORD_BITS-1], ty};
        dx_abs = dx_raw[DIFF_W-1] ? (~dx_raw + 1'b1) : dx_raw;
        dy_abs = dy_raw[DIFF_W-1] ? (~dy_raw + 1'b1) : dy_raw;
    end

    // Tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        idx_a_reg <= in_idx;
        dx_reg    <= dx_abs;
        dy_reg    <= dy_abs;

        idx_b_reg <= idx_a_reg;
        sx_reg    <= dx_reg * dx_reg;
        sy_reg    <= dy_reg * dy_reg;

        idx_c_reg <= idx_b_reg;
        sum_reg   <= {1'b0, sx_reg} + {1'b0, sy_reg};
    end

    assign out_tag  = tag_c_reg;
    assign out_idx  = idx_c_reg;
    assign out_dist = sum_reg;

endmodule
